// ===== rtl/gba_pkg.sv =====
// ----------------------------------------------------------------------------
// gba_pkg
// Types, field widths, mode, status and register codes of the allocator.
// ----------------------------------------------------------------------------
package gba_pkg;

  localparam int MODE_W    = 2;
  localparam int BLK_W     = 14;
  localparam int GSEL_W    = 3;
  localparam int WIDX_W    = 5;
  localparam int WORD_W    = 32;
  localparam int GCNT_W    = 11;
  localparam int TOT_W     = 14;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;
  localparam int BPG_CFG_W = 11;
  localparam int NG_CFG_W  = 4;

  localparam logic [GCNT_W-1:0] GCNT_MAX = '1;
  localparam logic [TOT_W-1:0]  TOT_MAX  = '1;

  localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_WORD = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD_CNT  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BPG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NG  = 1'd1;

  localparam logic [BPG_CFG_W-1:0] BPG_RESET = 11'd1024;
  localparam logic [NG_CFG_W-1:0]  NG_RESET  = 4'd8;

  typedef struct packed {
    logic [BLK_W-1:0]  result_block;
    logic [STAT_W-1:0] status;
    logic [TOT_W-1:0]  total_free;
  } gba_result_t;

  function automatic logic [4:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [4:0] k;
    k = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) k = 5'(i);
    end
    return k;
  endfunction

endpackage

// ===== rtl/gba_ifs.sv =====
// ----------------------------------------------------------------------------
// gba_ifs
// Request, response and configuration channels of the allocator.
// ----------------------------------------------------------------------------
interface gba_req_if;
  logic                           valid;
  logic                           ready;
  logic [gba_pkg::MODE_W-1:0]     mode;
  logic [gba_pkg::BLK_W-1:0]      block_no;
  logic [gba_pkg::GSEL_W-1:0]     group_select;
  logic [gba_pkg::WIDX_W-1:0]     word_index;
  logic [gba_pkg::WORD_W-1:0]     word_data;
  logic [gba_pkg::GCNT_W-1:0]     free_value;

  modport source (output valid, mode, block_no, group_select, word_index,
                  word_data, free_value, input ready);
  modport sink (input valid, mode, block_no, group_select, word_index,
                word_data, free_value, output ready);
endinterface

interface gba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [gba_pkg::BLK_W-1:0]  result_block;
  logic [gba_pkg::STAT_W-1:0] status;
  logic [gba_pkg::TOT_W-1:0]  total_free;

  modport source (output valid, result_block, status, total_free, input ready);
  modport sink (input valid, result_block, status, total_free, output ready);
endinterface

interface gba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gba_pkg::CFG_IDX_W-1:0] index;
  logic [gba_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gba_ram.sv =====
// ----------------------------------------------------------------------------
// gba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gba_ctrl.sv =====
// ----------------------------------------------------------------------------
// gba_ctrl
// Sequencer that scans, frees and loads map words one word at a time.
// ----------------------------------------------------------------------------
module gba_ctrl #(
  parameter int MAX_GROUPS = 8,
  parameter int MAP_BITS   = 1024,
  parameter int WPG        = (MAP_BITS + 31) / 32,
  parameter int DEPTH      = MAX_GROUPS * WPG,
  parameter int AW         = (DEPTH > 1 ? $clog2(DEPTH) : 1),
  parameter int BW         = $clog2(MAP_BITS + 1),
  parameter int GW         = $clog2(MAX_GROUPS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [BW-1:0]                 bpg,
  input  logic [GW-1:0]                 ng,
  input  logic                          start,
  input  logic [gba_pkg::MODE_W-1:0]    mode,
  input  logic [gba_pkg::BLK_W-1:0]     block_no,
  input  logic [gba_pkg::GSEL_W-1:0]    group_select,
  input  logic [gba_pkg::WIDX_W-1:0]    word_index,
  input  logic [gba_pkg::WORD_W-1:0]    word_data,
  input  logic [gba_pkg::GCNT_W-1:0]    free_value,
  output logic                          idle,
  output logic                          done,
  input  logic                          ack,
  output gba_pkg::gba_result_t          res,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [gba_pkg::WORD_W-1:0]    ram_wdata,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [gba_pkg::WORD_W-1:0]    ram_rdata
);

  localparam int GIW = (MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1);
  localparam int WIW = (WPG > 1 ? $clog2(WPG) : 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AGRP = 4'd1;
  localparam logic [3:0] S_ARD  = 4'd2;
  localparam logic [3:0] S_ACHK = 4'd3;
  localparam logic [3:0] S_FDIV = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FCHK = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0]                   state;
  logic [GW-1:0]                g;
  logic [WIW-1:0]               w;
  logic [gba_pkg::BLK_W-1:0]    base;
  logic [gba_pkg::BLK_W-1:0]    rem;
  logic [AW-1:0]                addr;
  logic [gba_pkg::BLK_W-1:0]    res_block;
  logic [gba_pkg::STAT_W-1:0]   res_status;
  logic [gba_pkg::GCNT_W-1:0]   cnt [MAX_GROUPS];
  logic [gba_pkg::TOT_W-1:0]    total;
  logic [DEPTH-1:0]             vld;

  logic [GIW-1:0]               gi;
  logic [GIW-1:0]               gsel_i;
  logic                         gsel_ok;
  logic                         widx_ok;
  logic [AW-1:0]                load_addr;
  logic [gba_pkg::WORD_W-1:0]   word;
  logic [31:0]                  wbase32;
  logic [31:0]                  lim32;
  logic [gba_pkg::WORD_W-1:0]   mask;
  logic [gba_pkg::WORD_W-1:0]   freebits;
  logic [4:0]                   k;
  logic                         last_word;
  logic                         rem_lt;
  logic [gba_pkg::GCNT_W-1:0]   old_cnt;
  logic [gba_pkg::TOT_W:0]      sum;
  logic [gba_pkg::TOT_W-1:0]    dec;
  logic [gba_pkg::TOT_W-1:0]    tot_load;

  always_comb begin
    gi        = GIW'(g);
    gsel_i    = GIW'(32'(group_select));
    gsel_ok   = 32'(group_select) < 32'(MAX_GROUPS);
    widx_ok   = 32'(word_index) < 32'(WPG);
    load_addr = AW'(32'(group_select) * 32'(WPG) + 32'(word_index));
    word      = vld[addr] ? ram_rdata : '0;
    wbase32   = 32'(w) << 5;
    lim32     = 32'(bpg) - wbase32;
    mask      = (lim32 >= 32'd32) ? '1 : ((32'd1 << lim32[4:0]) - 32'd1);
    freebits  = ~word & mask;
    k         = gba_pkg::lowest_set(freebits);
    last_word = (wbase32 + 32'd32) >= 32'(bpg);
    rem_lt    = 32'(rem) < 32'(bpg);
    old_cnt   = cnt[gsel_i];
    sum       = '0;
    dec       = '0;
    if (free_value >= old_cnt) begin
      sum = (gba_pkg::TOT_W + 1)'(total) + (gba_pkg::TOT_W + 1)'(free_value - old_cnt);
      tot_load = (sum > (gba_pkg::TOT_W + 1)'(gba_pkg::TOT_MAX)) ? gba_pkg::TOT_MAX
                                                                   : sum[gba_pkg::TOT_W-1:0];
    end else begin
      dec = gba_pkg::TOT_W'(old_cnt - free_value);
      tot_load = (total > dec) ? total - dec : '0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = word | (gba_pkg::WORD_W'(1) << k);
    ram_raddr = addr;
    case (state)
      S_IDLE: begin
        ram_we    = start && mode == gba_pkg::MODE_LOAD_WORD && gsel_ok && widx_ok;
        ram_waddr = load_addr;
        ram_wdata = word_data;
      end
      S_ACHK: begin
        ram_we = freebits != '0;
      end
      S_FCHK: begin
        ram_we    = word[rem[4:0]];
        ram_wdata = word & ~(gba_pkg::WORD_W'(1) << rem[4:0]);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      vld   <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            res_block  <= '0;
            res_status <= gba_pkg::ST_OK;
            g          <= '0;
            base       <= '0;
            rem        <= block_no - gba_pkg::BLK_W'(1);
            case (mode)
              gba_pkg::MODE_ALLOC: begin
                state <= S_AGRP;
              end
              gba_pkg::MODE_FREE: begin
                if (block_no == '0 || ng == '0) begin
                  res_status <= gba_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  state <= S_FDIV;
                end
              end
              gba_pkg::MODE_LOAD_CNT: begin
                if (gsel_ok) begin
                  cnt[gsel_i] <= free_value;
                  total       <= tot_load;
                end
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_AGRP: begin
          if (32'(g) >= 32'(ng)) begin
            res_status <= gba_pkg::ST_NO_FREE;
            state      <= S_DONE;
          end else if (cnt[gi] == '0) begin
            g    <= g + GW'(1);
            base <= base + gba_pkg::BLK_W'(bpg);
          end else begin
            w     <= '0;
            addr  <= AW'(32'(g) * 32'(WPG));
            state <= S_ARD;
          end
        end
        S_ARD: begin
          state <= S_ACHK;
        end
        S_ACHK: begin
          if (freebits != '0) begin
            cnt[gi] <= cnt[gi] - gba_pkg::GCNT_W'(1);
            if (total != '0) begin
              total <= total - gba_pkg::TOT_W'(1);
            end
            res_block <= base + gba_pkg::BLK_W'(wbase32) + gba_pkg::BLK_W'(k)
                         + gba_pkg::BLK_W'(1);
            state     <= S_DONE;
          end else if (last_word) begin
            g     <= g + GW'(1);
            base  <= base + gba_pkg::BLK_W'(bpg);
            state <= S_AGRP;
          end else begin
            w     <= w + WIW'(1);
            addr  <= addr + AW'(1);
            state <= S_ARD;
          end
        end
        S_FDIV: begin
          if (rem_lt) begin
            addr  <= AW'(32'(g) * 32'(WPG) + 32'(rem >> 5));
            state <= S_FRD;
          end else if (32'(g) + 32'd1 >= 32'(ng)) begin
            res_status <= gba_pkg::ST_RANGE;
            state      <= S_DONE;
          end else begin
            rem <= rem - gba_pkg::BLK_W'(bpg);
            g   <= g + GW'(1);
          end
        end
        S_FRD: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (word[rem[4:0]]) begin
            if (cnt[gi] != gba_pkg::GCNT_MAX) begin
              cnt[gi] <= cnt[gi] + gba_pkg::GCNT_W'(1);
            end
            if (total != gba_pkg::TOT_MAX) begin
              total <= total + gba_pkg::TOT_W'(1);
            end
          end else begin
            res_status <= gba_pkg::ST_NOT_ALLOC;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle             = state == S_IDLE;
  assign done             = state == S_DONE;
  assign res.result_block = res_block;
  assign res.status       = res_status;
  assign res.total_free   = total;

endmodule

// ===== rtl/grouped_bitmap_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator_core
// First-fit block allocator over per-group used-block bitmaps.
// ----------------------------------------------------------------------------
// One request is handled at a time. A load writes its map word or free count
// straight from the idle state. An allocate looks at the groups in order,
// skips a group whose free count is zero and reads the map words of any
// other group one by one, since all map words sit in one RAM with a single
// registered read port that the scan walks word by word; it reports no free
// block once it runs past the last group. A free steps past whole groups
// until its block number lies in one, then reads the map word and clears the
// block's bit; a free is out of range without any step when the block number
// is 0 or no group is in use, and otherwise when it passes the last group.
// A response waits in an output register, and a new request is accepted while
// it waits; that request's result is held back until the register is free.
module grouped_bitmap_block_allocator_core #(
  parameter int MAX_GROUPS = 8,
  parameter int MAP_BITS   = 1024
) (
  input  logic     clk,
  input  logic     rst,
  gba_req_if.sink   req,
  gba_rsp_if.source rsp,
  gba_cfg_if.sink   cfg
);

  localparam int WPG   = (MAP_BITS + 31) / 32;
  localparam int DEPTH = MAX_GROUPS * WPG;
  localparam int AW    = (DEPTH > 1 ? $clog2(DEPTH) : 1);
  localparam int BW    = $clog2(MAP_BITS + 1);
  localparam int GW    = $clog2(MAX_GROUPS + 1);

  logic [gba_pkg::BPG_CFG_W-1:0] bpg_cfg;
  logic [gba_pkg::NG_CFG_W-1:0]  ng_cfg;
  logic [BW-1:0]                 bpg;
  logic [GW-1:0]                 ng;
  logic                          idle;
  logic                          done;
  logic                          ack;
  gba_pkg::gba_result_t          res;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [gba_pkg::WORD_W-1:0]    ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [gba_pkg::WORD_W-1:0]    ram_rdata;
  logic                          out_valid;

  always_comb begin
    if (bpg_cfg == '0) begin
      bpg = BW'(1);
    end else if (32'(bpg_cfg) > 32'(MAP_BITS)) begin
      bpg = BW'(MAP_BITS);
    end else begin
      bpg = BW'(32'(bpg_cfg));
    end
    if (32'(ng_cfg) > 32'(MAX_GROUPS)) begin
      ng = GW'(MAX_GROUPS);
    end else begin
      ng = GW'(32'(ng_cfg));
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpg_cfg <= gba_pkg::BPG_RESET;
      ng_cfg  <= gba_pkg::NG_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        gba_pkg::CFG_BPG: bpg_cfg <= cfg.data;
        gba_pkg::CFG_NG:  ng_cfg  <= gba_pkg::NG_CFG_W'(cfg.data);
        default: begin
          bpg_cfg <= bpg_cfg;
        end
      endcase
    end
  end

  assign req.ready = idle;
  assign ack       = done && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid        <= 1'b1;
      rsp.result_block <= res.result_block;
      rsp.status       <= res.status;
      rsp.total_free   <= res.total_free;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid = out_valid;

  gba_ctrl #(
    .MAX_GROUPS (MAX_GROUPS),
    .MAP_BITS   (MAP_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .bpg          (bpg),
    .ng           (ng),
    .start        (req.valid && idle),
    .mode         (req.mode),
    .block_no     (req.block_no),
    .group_select (req.group_select),
    .word_index   (req.word_index),
    .word_data    (req.word_data),
    .free_value   (req.free_value),
    .idle         (idle),
    .done         (done),
    .ack          (ack),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  gba_ram #(
    .WIDTH (gba_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the grouped bitmap block allocator. Directed and
// random allocate, free and load transactions are checked field by field
// against an in-bench model of the maps and free counts, over several
// register settings.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NGRP      = 8;
  localparam int NWORDS    = 32;
  localparam int BITS_MAX  = 1024;
  localparam int STALL_MAX = 20000;

  typedef struct {
    logic [gba_pkg::MODE_W-1:0] mode;
    logic [gba_pkg::BLK_W-1:0]  blk;
    logic [gba_pkg::GSEL_W-1:0] gsel;
    logic [gba_pkg::WIDX_W-1:0] widx;
    logic [gba_pkg::WORD_W-1:0] wdata;
    logic [gba_pkg::GCNT_W-1:0] fval;
  } alloc_req_t;

  logic clk;
  logic rst;

  gba_req_if req ();
  gba_rsp_if rsp ();
  gba_cfg_if cfg ();

  grouped_bitmap_block_allocator_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  alloc_req_t           pending_reqs[$];
  gba_pkg::gba_result_t expected_results[$];

  logic [gba_pkg::WORD_W-1:0]    shadow_map[NGRP][NWORDS];
  int unsigned                   shadow_gcnt[NGRP];
  int unsigned                   shadow_total;
  logic [gba_pkg::BPG_CFG_W-1:0] shadow_bpg;
  logic [gba_pkg::NG_CFG_W-1:0]  shadow_ng;

  int  errors;
  int  stall_cycles;
  int  req_gap;
  int  rsp_gap;
  bit  idle_on;
  bit  req_fired;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int eff_bpg();
    if (shadow_bpg == 0) return 1;
    if (shadow_bpg > BITS_MAX) return BITS_MAX;
    return shadow_bpg;
  endfunction

  function automatic int eff_groups();
    return (shadow_ng > NGRP) ? NGRP : shadow_ng;
  endfunction

  function automatic gba_pkg::gba_result_t predict_allocator(alloc_req_t it);
    gba_pkg::gba_result_t r;
    int bpg, ng, lim, g, i, oldc;
    bit found;
    bpg = eff_bpg();
    ng = eff_groups();
    r.result_block = '0;
    r.status = gba_pkg::ST_OK;
    found = 0;
    case (it.mode)
      gba_pkg::MODE_ALLOC: begin
        r.status = gba_pkg::ST_NO_FREE;
        for (g = 0; g < ng && !found; g++) begin
          if (shadow_gcnt[g] == 0) continue;
          for (i = 0; i < bpg; i++) begin
            if (!shadow_map[g][i/32][i%32]) begin
              shadow_map[g][i/32][i%32] = 1'b1;
              shadow_gcnt[g]--;
              if (shadow_total > 0) shadow_total--;
              r.result_block = gba_pkg::BLK_W'(g * bpg + i + 1);
              r.status = gba_pkg::ST_OK;
              found = 1;
              break;
            end
          end
        end
      end
      gba_pkg::MODE_FREE: begin
        lim = ng * bpg;
        if (it.blk == 0 || it.blk > lim) begin
          r.status = gba_pkg::ST_RANGE;
        end else begin
          g = (it.blk - 1) / bpg;
          i = (it.blk - 1) % bpg;
          if (shadow_map[g][i/32][i%32]) begin
            shadow_map[g][i/32][i%32] = 1'b0;
            if (shadow_gcnt[g] < gba_pkg::GCNT_MAX) shadow_gcnt[g]++;
            if (shadow_total < gba_pkg::TOT_MAX) shadow_total++;
          end else begin
            r.status = gba_pkg::ST_NOT_ALLOC;
          end
        end
      end
      gba_pkg::MODE_LOAD_WORD: begin
        shadow_map[it.gsel][it.widx] = it.wdata;
      end
      default: begin
        oldc = shadow_gcnt[it.gsel];
        if (it.fval >= oldc) begin
          shadow_total = shadow_total + (it.fval - oldc);
          if (shadow_total > gba_pkg::TOT_MAX) shadow_total = gba_pkg::TOT_MAX;
        end else begin
          shadow_total = (shadow_total > oldc - it.fval) ? shadow_total - (oldc - it.fval) : 0;
        end
        shadow_gcnt[it.gsel] = it.fval;
      end
    endcase
    r.total_free = gba_pkg::TOT_W'(shadow_total);
    return r;
  endfunction

  function automatic int pick_gap();
    if (!idle_on) return 0;
    case ($urandom_range(0, 19))
      0:       return $urandom_range(15, 60);
      1, 2, 3: return $urandom_range(1, 4);
      4, 5:    return 1;
      default: return 0;
    endcase
  endfunction

  always @(negedge clk) begin
    logic nv;
    alloc_req_t it;
    nv = req.valid;
    if (rst) begin
      nv = 1'b0;
    end else if (!req.valid || req_fired) begin
      nv = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
      end else if (pending_reqs.size() > 0) begin
        it = pending_reqs.pop_front();
        req.mode <= it.mode;
        req.block_no <= it.blk;
        req.group_select <= it.gsel;
        req.word_index <= it.widx;
        req.word_data <= it.wdata;
        req.free_value <= it.fval;
        nv = 1'b1;
        req_gap = pick_gap();
      end
    end
    req.valid <= nv;
    if (rsp_gap > 0) begin
      rsp_gap--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      rsp_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    gba_pkg::gba_result_t exp_r;
    alloc_req_t it;
    req_fired = 1'b0;
    if (!rst) begin
      stall_cycles++;
      if (rsp.valid && rsp.ready) begin
        stall_cycles = 0;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result block=%0d status=%0d total=%0d", $time,
                   rsp.result_block, rsp.status, rsp.total_free);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (rsp.result_block !== exp_r.result_block)
            $display("%0t: result_block expected %0d actual %0d", $time,
                     exp_r.result_block, rsp.result_block);
          if (rsp.status !== exp_r.status)
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, rsp.status);
          if (rsp.total_free !== exp_r.total_free)
            $display("%0t: total_free expected %0d actual %0d", $time,
                     exp_r.total_free, rsp.total_free);
          if (rsp.result_block !== exp_r.result_block || rsp.status !== exp_r.status ||
              rsp.total_free !== exp_r.total_free)
            errors++;
        end
      end
      if (req.valid && req.ready) begin
        stall_cycles = 0;
        req_fired = 1'b1;
        it.mode = req.mode;
        it.blk = req.block_no;
        it.gsel = req.group_select;
        it.widx = req.word_index;
        it.wdata = req.word_data;
        it.fval = req.free_value;
        expected_results.push_back(predict_allocator(it));
      end
      if (cfg.valid && cfg.ready) begin
        stall_cycles = 0;
        if (cfg.index == gba_pkg::CFG_BPG) shadow_bpg = cfg.data[gba_pkg::BPG_CFG_W-1:0];
        else shadow_ng = cfg.data[gba_pkg::NG_CFG_W-1:0];
      end
      if (stall_cycles >= STALL_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic queue_req(logic [gba_pkg::MODE_W-1:0] m, int b, int g, int w,
                           logic [31:0] d, int f);
    alloc_req_t it;
    it.mode = m;
    it.blk = gba_pkg::BLK_W'(b);
    it.gsel = gba_pkg::GSEL_W'(g);
    it.widx = gba_pkg::WIDX_W'(w);
    it.wdata = d;
    it.fval = gba_pkg::GCNT_W'(f);
    pending_reqs.push_back(it);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || req.valid || expected_results.size() != 0)
      @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [gba_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg.index <= idx;
    cfg.data <= gba_pkg::CFG_DAT_W'(val);
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic queue_random(int count);
    int lim, k;
    lim = eff_groups() * eff_bpg();
    repeat (count) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        queue_req(gba_pkg::MODE_ALLOC, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (k < 70) begin
        if (lim > 0 && $urandom_range(0, 9) != 0)
          queue_req(gba_pkg::MODE_FREE, $urandom_range(1, lim), $urandom, $urandom,
                    $urandom, $urandom);
        else
          queue_req(gba_pkg::MODE_FREE, $urandom_range(0, 16383), $urandom, $urandom,
                    $urandom, $urandom);
      end else if (k < 85) begin
        queue_req(gba_pkg::MODE_LOAD_WORD, $urandom, $urandom_range(0, 7),
                  $urandom_range(0, 31), ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom,
                  $urandom);
      end else begin
        queue_req(gba_pkg::MODE_LOAD_CNT, $urandom, $urandom_range(0, 7), $urandom, $urandom,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(0, eff_bpg()));
      end
    end
  endtask

  initial begin
    int bpg_set[7] = '{1024, 1, 37, 0, 2047, 64, 100};
    int ng_set[7]  = '{8, 1, 3, 8, 15, 0, 8};
    rst = 1'b1;
    req.valid = 1'b0;
    req.mode = gba_pkg::MODE_ALLOC;
    req.block_no = '0;
    req.group_select = '0;
    req.word_index = '0;
    req.word_data = '0;
    req.free_value = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = gba_pkg::CFG_BPG;
    cfg.data = '0;
    errors = 0;
    stall_cycles = 0;
    req_gap = 0;
    rsp_gap = 0;
    idle_on = 1'b1;
    shadow_bpg = gba_pkg::BPG_RESET;
    shadow_ng = gba_pkg::NG_RESET;
    shadow_total = 0;
    for (int g = 0; g < NGRP; g++) begin
      shadow_gcnt[g] = 0;
      for (int w = 0; w < NWORDS; w++) shadow_map[g][w] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_req(gba_pkg::MODE_ALLOC, 0, 0, 0, 0, 0);
    queue_req(gba_pkg::MODE_LOAD_CNT, 0, 0, 0, 0, 5);
    queue_req(gba_pkg::MODE_ALLOC, 0, 0, 0, 0, 0);
    queue_req(gba_pkg::MODE_FREE, 1, 0, 0, 0, 0);
    queue_req(gba_pkg::MODE_FREE, 1, 0, 0, 0, 0);
    queue_req(gba_pkg::MODE_FREE, 0, 0, 0, 0, 0);
    queue_req(gba_pkg::MODE_FREE, 8193, 0, 0, 0, 0);
    queue_req(gba_pkg::MODE_FREE, 16383, 0, 0, 0, 0);
    queue_req(gba_pkg::MODE_LOAD_WORD, 0, 0, 0, 32'hFFFF_FFFF, 0);
    queue_req(gba_pkg::MODE_ALLOC, 0, 0, 0, 0, 0);
    queue_req(gba_pkg::MODE_FREE, 8192, 7, 31, 0, 0);
    queue_req(gba_pkg::MODE_LOAD_WORD, 0, 7, 31, 32'h8000_0000, 0);
    queue_req(gba_pkg::MODE_FREE, 8192, 0, 0, 0, 0);
    for (int g = 0; g < NGRP; g++) queue_req(gba_pkg::MODE_LOAD_CNT, 0, g, 0, 0, 2047);
    queue_req(gba_pkg::MODE_FREE, 8192, 0, 0, 0, 0);
    queue_req(gba_pkg::MODE_LOAD_CNT, 0, 3, 0, 0, 0);
    queue_req(gba_pkg::MODE_ALLOC, 0, 0, 0, 0, 0);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(gba_pkg::CFG_BPG, bpg_set[p]);
      write_reg(gba_pkg::CFG_NG, ng_set[p]);
      idle_on = (p % 3) != 2;
      queue_random(p == 0 ? 150 : 300);
      drain();
    end

    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/gba_pkg.sv
rtl/gba_ifs.sv
rtl/gba_ram.sv
rtl/gba_ctrl.sv
rtl/grouped_bitmap_block_allocator_core.sv
tb/sv/testbench.sv
